// ===== hdl/cbp_pkg.sv =====
// Package with the shared types and constants of the chunky-to-bitplane packer.
package cbp_pkg;

    localparam int MAX_PLANES      = 4;
    localparam int PLANE_BYTES     = 8192;
    localparam int MAX_ROW_PIXELS  = 320;

    localparam int GROUP_PIXELS    = 8;
    localparam int TOP_BIT         = 7;

    localparam int PIXEL_W         = 4;
    localparam int PLANE_FIELD_W   = 2;
    localparam int ADDR_W          = $clog2(PLANE_BYTES);
    localparam int COL_W           = 9;
    localparam int PCOUNT_W        = 3;
    localparam int BITPOS_W        = $clog2(GROUP_PIXELS);
    localparam int PLANE_IDX_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 9;

    localparam int GROUP_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W       = $clog2(GROUP_FIFO_DEPTH);

    localparam logic [PCOUNT_W-1:0] PLANE_COUNT_RESET = PCOUNT_W'(1);
    localparam logic [COL_W-1:0]    ROW_WIDTH_RESET   = COL_W'(320);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLANE_COUNT = 2'd0,
        CFG_ROW_WIDTH   = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_index;
        logic               frame_start;
    } pixel_beat_t;

    typedef struct packed {
        logic [PLANE_FIELD_W-1:0] plane;
        logic [ADDR_W-1:0]        byte_address;
        logic [7:0]               plane_byte;
        logic                     last_plane;
    } packed_beat_t;

    // One finished group of eight (or fewer) pixels, all planes.
    typedef struct packed {
        logic [MAX_PLANES-1:0][7:0] plane_bytes;
        logic [ADDR_W-1:0]          byte_address;
        logic [PLANE_IDX_W-1:0]     last_idx;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== hdl/chunky_to_bitplane_packer.sv =====
// Top level of the chunky-to-bitplane packer: configuration registers and the three parts.
//
// Use of the block:
//   Pixels come in on the pixel channel (pixel_valid, pixel_ready, pixel_data),
//   one palette index per beat in raster order. A beat with frame_start set
//   clears the row position, the partial group and the byte address first.
//   Each group of eight pixels, or the shorter group at a row end, leaves on
//   the packed channel as one beat per plane in use, planes 0 upward, all
//   with the same byte address; last_plane marks the final beat of a group.
//   The front end takes one pixel per cycle and hands each finished group to
//   a four-entry group queue; the drain sends one plane byte per cycle from
//   an output register, so the first beat of a group appears once the group
//   is queued and then loaded into that register. Sustained input rate is one
//   pixel per cycle as long as groups need no more beats than they have
//   pixels; otherwise the drain's one beat per cycle sets the pace.
//   When the receiver stalls, the output beat holds, the queue fills and then
//   pixel_ready falls until a group slot frees up.
//   Reset clears the position, the address and the queue, and sets one plane
//   and a 320-pixel row. Configuration writes are registered and are meant
//   for idle periods only.
module chunky_to_bitplane_packer
    import cbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  pixel_beat_t            pixel_data,
    output logic                   packed_valid,
    input  logic                   packed_ready,
    output packed_beat_t           packed_data
);

    logic [PCOUNT_W-1:0] plane_count_reg;
    logic [COL_W-1:0]    row_width_reg;

    logic         accept;
    logic         push;
    logic         pop;
    group_t       push_group;
    group_t       head;
    fifo_status_t status;

    // Register writes; an index outside the list is simply ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= PLANE_COUNT_RESET;
            row_width_reg   <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PLANE_COUNT: plane_count_reg <= cfg_data[PCOUNT_W-1:0];
                CFG_ROW_WIDTH:   row_width_reg   <= cfg_data[COL_W-1:0];
                default:         ;
            endcase
        end
    end

    // The front end stalls only when the queue has no room for a group.
    assign pixel_ready = !status.full;
    assign accept      = pixel_valid && pixel_ready;

    cbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .plane_count (plane_count_reg),
        .row_width   (row_width_reg),
        .accept      (accept),
        .pixel_data  (pixel_data),
        .push        (push),
        .push_group  (push_group)
    );

    cbp_group_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    cbp_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .packed_ready (packed_ready),
        .packed_valid (packed_valid),
        .packed_data  (packed_data)
    );

endmodule

// ===== hdl/cbp_front.sv =====
// Front end: accepts pixels, collects plane bits and closes groups.
module cbp_front
    import cbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PCOUNT_W-1:0] plane_count,
    input  logic [COL_W-1:0]    row_width,
    input  logic                accept,
    input  pixel_beat_t         pixel_data,
    output logic                push,
    output group_t              push_group
);

    logic [COL_W-1:0]    column_reg, column_next;
    logic [BITPOS_W-1:0] bit_reg, bit_next;
    logic [7:0]          shift_reg [MAX_PLANES];
    logic [7:0]          shift_next [MAX_PLANES];
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic [COL_W-1:0]    base_col;
    logic [BITPOS_W-1:0] base_bit;
    logic [ADDR_W-1:0]   base_addr;
    logic [COL_W:0]      col_inc;
    logic [COL_W-1:0]    width_use;
    logic [PCOUNT_W-1:0] planes_use;
    logic                row_end;
    logic                complete;
    logic [7:0]          merged [MAX_PLANES];

    always_comb
    begin
        if (row_width == '0)
            width_use = COL_W'(1);
        else if (row_width > COL_W'(MAX_ROW_PIXELS))
            width_use = COL_W'(MAX_ROW_PIXELS);
        else
            width_use = row_width;

        if (plane_count == '0)
            planes_use = PCOUNT_W'(1);
        else if (plane_count > PCOUNT_W'(MAX_PLANES))
            planes_use = PCOUNT_W'(MAX_PLANES);
        else
            planes_use = plane_count;
    end

    always_comb
    begin
        base_col  = pixel_data.frame_start ? '0 : column_reg;
        base_bit  = pixel_data.frame_start ? '0 : bit_reg;
        base_addr = pixel_data.frame_start ? '0 : addr_reg;
        for (int k = 0; k < MAX_PLANES; k++)
        begin
            merged[k] = pixel_data.frame_start ? 8'd0 : shift_reg[k];
            if (k < PIXEL_W)
                merged[k] = merged[k] |
                    (8'(pixel_data.pixel_index[k]) << (BITPOS_W'(TOP_BIT) - base_bit));
        end
        col_inc  = {1'b0, base_col} + (COL_W+1)'(1);
        row_end  = col_inc >= {1'b0, width_use};
        complete = (base_bit == BITPOS_W'(TOP_BIT)) || row_end;

        column_next = column_reg;
        bit_next    = bit_reg;
        addr_next   = addr_reg;
        for (int k = 0; k < MAX_PLANES; k++)
            shift_next[k] = shift_reg[k];
        push = 1'b0;

        for (int k = 0; k < MAX_PLANES; k++)
            push_group.plane_bytes[k] = merged[k];
        push_group.byte_address = base_addr;
        push_group.last_idx     = PLANE_IDX_W'(planes_use - PCOUNT_W'(1));

        if (accept)
        begin
            if (complete)
            begin
                push        = 1'b1;
                addr_next   = base_addr + ADDR_W'(1);
                bit_next    = '0;
                column_next = row_end ? '0 : col_inc[COL_W-1:0];
                for (int k = 0; k < MAX_PLANES; k++)
                    shift_next[k] = 8'd0;
            end
            else
            begin
                addr_next   = base_addr;
                bit_next    = base_bit + BITPOS_W'(1);
                column_next = col_inc[COL_W-1:0];
                for (int k = 0; k < MAX_PLANES; k++)
                    shift_next[k] = merged[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            bit_reg    <= '0;
            addr_reg   <= '0;
            for (int k = 0; k < MAX_PLANES; k++)
                shift_reg[k] <= 8'd0;
        end
        else
        begin
            column_reg <= column_next;
            bit_reg    <= bit_next;
            addr_reg   <= addr_next;
            for (int k = 0; k < MAX_PLANES; k++)
                shift_reg[k] <= shift_next[k];
        end
    end

endmodule

// ===== hdl/cbp_group_fifo.sv =====
// Short queue of finished groups between the front end and the drain.
module cbp_group_fifo
    import cbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  group_t       push_group,
    input  logic         pop,
    output group_t       head,
    output fifo_status_t status
);

    group_t                mem [GROUP_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    always_comb
    begin
        status.full  = count_reg == (FIFO_PTR_W+1)'(GROUP_FIFO_DEPTH);
        status.empty = count_reg == '0;
        head         = mem[rd_ptr_reg];
        wr_ptr_next  = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("group queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_W+1)'(GROUP_FIFO_DEPTH))
        else $error("group queue count out of range");

endmodule

// ===== hdl/cbp_drain.sv =====
// Back end: sends the plane bytes of each queued group, one beat per cycle while the receiver accepts.
module cbp_drain
    import cbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  group_t       head,
    input  fifo_status_t status,
    output logic         pop,
    input  logic         packed_ready,
    output logic         packed_valid,
    output packed_beat_t packed_data
);

    logic [PLANE_IDX_W-1:0] sub_reg, sub_next;
    logic                   valid_reg, valid_next;
    packed_beat_t           data_reg, data_next;
    logic                   load;
    logic                   last;

    always_comb
    begin
        load       = !status.empty && (!valid_reg || packed_ready);
        last       = sub_reg == head.last_idx;
        pop        = load && last;
        sub_next   = sub_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next             = 1'b1;
            data_next.plane        = PLANE_FIELD_W'(sub_reg);
            data_next.byte_address = head.byte_address;
            data_next.plane_byte   = head.plane_bytes[sub_reg];
            data_next.last_plane   = last;
            sub_next               = last ? '0 : sub_reg + PLANE_IDX_W'(1);
        end
        else if (packed_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign packed_valid = valid_reg;
    assign packed_data  = data_reg;

endmodule
